// ----- rtl/fsp2_pkg.sv -----
// fsp2_pkg: types and constants for the single-precision power-of-two scaler
// used by fsp2_core and float_scale_by_power_of_two_top
`default_nettype none
package fsp2_pkg;
    localparam int unsigned EXP_W = 8;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned SIG_W = 24;
    localparam int unsigned BE_W = 35;
    localparam logic [EXP_W-1:0] EXP_MAX = 8'hFF;
    localparam logic [4:0] SHIFT_CAP = 5'd26;

    typedef struct packed {
        logic        sign;
        logic        pass;
        logic        ovf;
        logic [SIG_W-1:0] sig;
        logic signed [BE_W-1:0] be;
        logic [31:0] orig;
    } fsp2_stage_t;
endpackage
`default_nettype wire

// ----- rtl/fsp2_core.sv -----
// fsp2_core: four-stage pipeline that scales a float by a power of two
// depends on fsp2_pkg; stall by a common enable
`default_nettype none
module fsp2_core
    import fsp2_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         en,
    input  wire         in_valid,
    input  wire  [31:0] value_bits,
    input  wire  [31:0] scale_exponent,
    output logic        out_valid,
    output logic [31:0] result_bits,
    output logic        overflow,
    output logic        underflow
);
    // stage 1: unpack, normalise subnormal
    logic [3:0] v_reg;
    fsp2_stage_t s1_reg, s1_next;
    logic signed [BE_W-1:0] n1_reg;
    logic [4:0] lz;
    logic [EXP_W-1:0] ef;
    logic [FRAC_W-1:0] fr;

    always_comb
    begin
        ef = value_bits[30:23];
        fr = value_bits[22:0];
        lz = 5'd0;
        for (int i = 0; i < FRAC_W; i++)
        begin
            if (fr[i])
            begin
                lz = 5'(FRAC_W - i);
            end
        end
        s1_next.sign = value_bits[31];
        s1_next.orig = value_bits;
        s1_next.ovf = 1'b0;
        s1_next.pass = (scale_exponent == 32'd0) || (ef == EXP_MAX) || (ef == '0 && fr == '0);
        if (ef == '0)
        begin
            s1_next.sig = {1'b0, fr} << lz;
            s1_next.be = BE_W'(1) - BE_W'(lz);
        end
        else
        begin
            s1_next.sig = {1'b1, fr};
            s1_next.be = BE_W'(ef);
        end
    end

    // stage 2: add exponent, decide range
    fsp2_stage_t s2_reg, s2_next;
    logic [4:0] sh2_next, sh2_reg;
    logic signed [BE_W-1:0] shf;
    always_comb
    begin
        s2_next = s1_reg;
        s2_next.be = s1_reg.be + n1_reg;
        s2_next.ovf = s2_next.be >= BE_W'(signed'({1'b0, EXP_MAX}));
        shf = BE_W'(1) - s2_next.be;
        sh2_next = (shf > BE_W'(signed'({1'b0, SHIFT_CAP}))) ? SHIFT_CAP : shf[4:0];
    end

    // stage 3: denormalise shift, round
    fsp2_stage_t s3_reg;
    logic [31:0] r3_reg, r3_next;
    logic u3_reg, u3_next;
    logic [31:0] q, rem, half, msk;
    always_comb
    begin
        q = 32'(s2_reg.sig) >> sh2_reg;
        msk = (32'd1 << sh2_reg) - 32'd1;
        rem = 32'(s2_reg.sig) & msk;
        half = 32'd1 << (sh2_reg - 5'd1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 32'd1;
        end
        u3_next = 1'b0;
        if (s2_reg.pass)
        begin
            r3_next = s2_reg.orig;
        end
        else if (s2_reg.ovf)
        begin
            r3_next = {s2_reg.sign, 31'h7F800000};
        end
        else if (s2_reg.be >= BE_W'(1))
        begin
            r3_next = {s2_reg.sign, s2_reg.be[7:0], s2_reg.sig[22:0]};
        end
        else
        begin
            r3_next = {s2_reg.sign, 7'd0, q[23:0]};
            u3_next = rem != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            n1_reg <= BE_W'(signed'(scale_exponent));
            s2_reg <= s2_next;
            sh2_reg <= sh2_next;
            s3_reg <= s2_reg;
            r3_reg <= r3_next;
            u3_reg <= u3_next;
            result_bits <= r3_reg;
            overflow <= s3_reg.ovf && !s3_reg.pass;
            underflow <= u3_reg;
        end
    end

    assign out_valid = v_reg[3];
endmodule
`default_nettype wire

// ----- rtl/float_scale_by_power_of_two_top.sv -----
// float_scale_by_power_of_two_top: stream wrapper of the ldexpf pipeline
// depends on fsp2_pkg and fsp2_core
//
// usage
//   s_axis beat: tdata = value_bits[31:0], scale_exponent[63:32]
//   m_axis beat: tdata = result_bits[31:0], overflow[32], underflow[33],
//   zero fill to bit 39
//   one beat accepted per cycle unless the receiver stalls; an input beat
//   reaches output valid through the four pipeline register stages
//   (unpack/normalise, exponent add, shift/round, output)
//   when the receiver stalls with a valid output beat the whole pipeline
//   holds; s_axis_tready is low only then, and bubbles inside the
//   pipeline are kept, not squeezed out
//   reset (rst_n low, asynchronous) empties all stage valid bits
//   no configuration, no state between beats
`default_nettype none
module float_scale_by_power_of_two_top
    import fsp2_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,  // value_bits, scale_exponent
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata   // result_bits, overflow, underflow
);
    logic en, ov, of, uf;
    logic [31:0] rb;

    assign en = m_axis_tready || !ov;
    assign s_axis_tready = en;

    fsp2_core u_core (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .value_bits(s_axis_tdata[31:0]),
        .scale_exponent(s_axis_tdata[63:32]),
        .out_valid(ov), .result_bits(rb), .overflow(of), .underflow(uf)
    );

    assign m_axis_tvalid = ov;
    assign m_axis_tdata = {6'd0, uf, of, rb};
endmodule
`default_nettype wire

// ----- sim/tb_float_scale_by_power_of_two_top.sv -----
// testbench for float_scale_by_power_of_two_top: single-precision ldexp over stream ports
// depends on the top level and, through it, on fsp2_pkg; predicts each result beat and checks it in order
`default_nettype none
module tb_float_scale_by_power_of_two_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        overflow;
        logic        underflow;
    } scaled_t;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] FRAC_BITS = 32'h007F_FFFF;
    localparam logic [31:0] HIDDEN = 32'h0080_0000;
    localparam logic [31:0] INF_BITS = 32'h7F80_0000;
    localparam int          EXP_TOP = 255;
    localparam int          MAX_SHIFT = 26;
    localparam int          CYCLE_LIMIT = 400000;

    scaled_t     expected_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    int          sent = 0;
    int          checked = 0;
    longint      cycles = 0;

    float_scale_by_power_of_two_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // value_bits, scale_exponent
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // result_bits, overflow, underflow
    );

    always #5 clk = ~clk;

    function automatic scaled_t scale_pow2(logic [31:0] v, logic signed [31:0] n);
        scaled_t     r;
        logic [31:0] sig;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        longint      be;
        int          sh;
        logic [7:0]  ef;
        r.result_bits = v;
        r.overflow = 1'b0;
        r.underflow = 1'b0;
        ef = v[30:23];
        if (n != 0 && ef != 8'hFF && v[30:0] != 0)
        begin
            if (ef == 0)
            begin
                sig = v & FRAC_BITS;
                be = 1;
                while (sig < HIDDEN)
                begin
                    sig = sig << 1;
                    be--;
                end
            end
            else
            begin
                sig = (v & FRAC_BITS) | HIDDEN;
                be = ef;
            end
            be = be + longint'(n);
            if (be >= EXP_TOP)
            begin
                r.result_bits = (v & SIGN_BIT) | INF_BITS;
                r.overflow = 1'b1;
            end
            else if (be >= 1)
                r.result_bits = (v & SIGN_BIT) | (32'(be) << 23) | (sig & FRAC_BITS);
            else
            begin
                sh = (1 - be > MAX_SHIFT) ? MAX_SHIFT : int'(1 - be);
                q = sig >> sh;
                rem = sig & ((32'd1 << sh) - 32'd1);
                half = 32'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0]))
                    q++;
                r.result_bits = (v & SIGN_BIT) | q;
                r.underflow = (rem != 0);
            end
        end
        return r;
    endfunction

    task automatic send_operand(logic [31:0] v, logic signed [31:0] n);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {n, v};
        expected_q.push_back(scale_pow2(v, n));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    // receiver stalls and checks each beat against the oldest prediction
    always @(posedge clk)
    begin
        scaled_t got;
        scaled_t exp_r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33]};
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    checked++;
                    if (got.result_bits !== exp_r.result_bits)
                    begin
                        $error("result_bits expected %h actual %h",
                               exp_r.result_bits, got.result_bits);
                        errors++;
                    end
                    if (got.overflow !== exp_r.overflow)
                    begin
                        $error("overflow expected %b actual %b", exp_r.overflow, got.overflow);
                        errors++;
                    end
                    if (got.underflow !== exp_r.underflow)
                    begin
                        $error("underflow expected %b actual %b",
                               exp_r.underflow, got.underflow);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(5))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[30:0] = '0;
            3: v[30:23] = $urandom_range(8'hFE, 8'hE0);
            4: v[30:23] = $urandom_range(8'h20, 8'h01);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] random_exponent();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(300)) - 150);
            2: return 32'($signed($urandom_range(60)) - 30);
            3: return 32'($signed($urandom_range(40)) - 20) + (($urandom_range(1)) ? 32'sd150 : -32'sd150);
            default: return ($urandom_range(1)) ? 32'sh8000_0000 + $urandom_range(3)
                                                 : 32'sh7FFF_FFFF - $urandom_range(3);
        endcase
    endfunction

    task automatic test_special_cases();
        send_operand(32'h3FC0_0000, 32'sd0);
        send_operand(32'h7FC0_0001, 32'sd5);
        send_operand(32'hFF80_0000, -32'sd5);
        send_operand(32'h8000_0000, 32'sd100);
        send_operand(32'h0000_0000, -32'sd100);
        send_operand(32'h0000_0001, 32'sd10);
        send_operand(32'h807F_FFFF, 32'sd1);
        send_operand(32'h7F7F_FFFF, 32'sd1);
        send_operand(32'hFF7F_FFFF, 32'sh7FFF_FFFF);
        send_operand(32'h3F80_0000, 32'sd127);
        send_operand(32'h3F80_0000, 32'sd128);
        send_operand(32'h3F80_0000, -32'sd126);
        send_operand(32'h3F80_0000, -32'sd149);
        send_operand(32'h3FC0_0000, -32'sd150);
        send_operand(32'h3F80_0000, -32'sd150);
        send_operand(32'h3FFF_FFFF, -32'sd126);
        send_operand(32'h00FF_FFFF, -32'sd1);
        send_operand(32'hBF80_0001, -32'sd127);
        send_operand(32'h7F7F_FFFF, 32'sh8000_0000);
        send_operand(32'hFFFF_FFFF, 32'sh8000_0000);
        send_operand(32'h4000_0000, -32'sd1);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_operand(random_value(), random_exponent());
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_random(125, 0, 0);
        test_random(125, 74, 0);
        test_random(125, 0, 74);
        test_random(125, 26, 26);
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        $display("covered %0d operands, %0d results checked: specials, overflow, subnormal rounding",
                 sent, checked);
        $display("idle phases: none, sender gaps, receiver stalls, both together");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/fsp2_pkg.sv
rtl/fsp2_core.sv
rtl/float_scale_by_power_of_two_top.sv
sim/tb_float_scale_by_power_of_two_top.sv
